// ----- src/longest_run_word_aligner_macros.svh -----
// ---------------------------------------------------------------------------
// Longest-run word aligner assertion macros
// Shared assertion forms used by the aligner RTL.
// ---------------------------------------------------------------------------
`ifndef LONGEST_RUN_WORD_ALIGNER_MACROS_SVH
`define LONGEST_RUN_WORD_ALIGNER_MACROS_SVH

// Asserts an implication that is checked on every clock edge outside reset.
`define LRWA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Asserts a next-cycle implication outside reset.
`define LRWA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- src/lrwa_pkg.sv -----
// ---------------------------------------------------------------------------
// Longest-run word aligner package
// Shared constants and types of the aligner.
// ---------------------------------------------------------------------------
package lrwa_pkg;
  localparam int MaxWordsDefault = 32;
  localparam int RowW = 32;
  localparam int IdxW = 5;
  localparam int CntW = 6;
  localparam logic ActLoad = 1'b0;
  localparam logic ActCompute = 1'b1;
  localparam logic SideRight = 1'b0;
  localparam logic SideLeft = 1'b1;

  typedef struct packed {
    logic action;
    logic [IdxW-1:0] row_index;
    logic [RowW-1:0] row_bits;
    logic [CntW-1:0] left_count;
    logic [CntW-1:0] right_count;
  } in_item_t;

  typedef struct packed {
    logic side;
    logic [IdxW-1:0] word_index;
    logic partner_valid;
    logic [IdxW-1:0] partner_index;
    logic [CntW-1:0] aligned_total;
    logic last;
  } out_item_t;
endpackage

// ----- src/lrwa_in_if.sv -----
// ---------------------------------------------------------------------------
// Aligner input channel
// Valid/ready channel that carries one input transaction.
// ---------------------------------------------------------------------------
interface lrwa_in_if
  import lrwa_pkg::*;
();
  logic valid;
  logic ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- src/lrwa_out_if.sv -----
// ---------------------------------------------------------------------------
// Aligner result channel
// Valid/ready channel that carries one result transaction.
// ---------------------------------------------------------------------------
interface lrwa_out_if
  import lrwa_pkg::*;
();
  logic valid;
  logic ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- src/lrwa_ram.sv -----
// ---------------------------------------------------------------------------
// Aligner generic RAM
// Single write port, single read port, registered read data.
// ---------------------------------------------------------------------------
module lrwa_ram #(
  parameter int Width = 32,
  parameter int Depth = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- src/longest_run_word_aligner.sv -----
// ---------------------------------------------------------------------------
// Longest-run word aligner
// A load transaction writes one match row, and loads can follow back to
// back. A compute transaction copies the active rows into a working matrix,
// addressing each row in the RAM and then capturing its registered read
// data, then scans every diagonal start with one shared bit-compare unit,
// one matrix bit per cycle. The best run is then recorded and cleared from
// the matrix. Each unaligned right word then reduces its start column by
// repeated subtraction and probes one column per cycle, up to L columns;
// an aligned right word is skipped. The left partners are then found, and
// finally R+L results leave at one per cycle while the sink is ready.
// Compute time is data dependent and set by the single shared compare
// unit; no further input is taken until the last result has been handed
// over.
// ---------------------------------------------------------------------------
`include "longest_run_word_aligner_macros.svh"
module longest_run_word_aligner
  import lrwa_pkg::*;
#(
  parameter int MAX_WORDS = MaxWordsDefault
) (
  input logic clk,
  input logic rst_n,
  lrwa_in_if.sink in_ch,
  lrwa_out_if.source out_ch
);
  localparam int Lim = (MAX_WORDS < 32) ? MAX_WORDS : 32;
  localparam int AW = $clog2(Lim);
  localparam logic [CntW-1:0] LimC = CntW'(Lim);
  localparam logic [CntW-1:0] None = {CntW{1'b1}};

  localparam logic [3:0] S_IDLE = 4'd0, S_COPY = 4'd1, S_COPYW = 4'd2,
    S_SCAN = 4'd3, S_CLR = 4'd4, S_GRD = 4'd5, S_GRD2 = 4'd6,
    S_LEFT = 4'd7, S_EMIT = 4'd8, S_MOD = 4'd9;

  logic [3:0] state_r, state_nxt;
  logic [RowW-1:0] work_r [Lim];
  logic [CntW-1:0] rp_r [Lim];
  logic [CntW-1:0] lp_r [Lim];
  logic [CntW-1:0] lc_r, rc_r, pairs_r, best_len_r, len_r;
  logic [CntW-1:0] bi_r, bj_r, i_r, j_r, k_r, col_r, cnt_r;
  logic [RowW-1:0] lmask_r;
  logic [CntW-1:0] eidx_r;
  logic eside_r;
  logic [RowW-1:0] rd;
  logic [AW-1:0] raddr;
  logic we;
  logic [CntW-1:0] lcc, rcc;

  always_comb begin
    lcc = (in_ch.data.left_count == '0) ? CntW'(1) :
          (in_ch.data.left_count > LimC) ? LimC : in_ch.data.left_count;
    rcc = (in_ch.data.right_count == '0) ? CntW'(1) :
          (in_ch.data.right_count > LimC) ? LimC : in_ch.data.right_count;
  end

  assign in_ch.ready = (state_r == S_IDLE);
  assign we = in_ch.valid && in_ch.ready && (in_ch.data.action == ActLoad) &&
              ({1'b0, in_ch.data.row_index} < LimC);
  assign raddr = k_r[AW-1:0];

  lrwa_ram #(.Width(RowW), .Depth(Lim)) u_ram (
    .clk(clk), .we(we), .waddr(in_ch.data.row_index[AW-1:0]),
    .wdata(in_ch.data.row_bits), .raddr(raddr), .rdata(rd)
  );

  // Bit probes of the shared compare unit.
  logic [CntW-1:0] pi, pj;
  logic probe;
  assign pi = i_r + len_r;
  assign pj = j_r + len_r;
  assign probe = (pi < lc_r) && (pj < rc_r) && work_r[pj[AW-1:0]][pi[IdxW-1:0]];
  logic gbit;
  assign gbit = work_r[j_r[AW-1:0]][col_r[IdxW-1:0]];

  // Row and column of the pair being cleared from the working matrix.
  logic [CntW-1:0] rj, ci;
  logic [AW-1:0] crow;
  logic [RowW-1:0] ckeep;
  assign rj = bj_r + k_r;
  assign ci = bi_r + k_r;
  assign crow = (state_r == S_CLR) ? rj[AW-1:0] : j_r[AW-1:0];
  assign ckeep = ~(RowW'(1) << ((state_r == S_CLR) ? ci[IdxW-1:0] : col_r[IdxW-1:0]));

  // Lowest right word aligned to the current left word.
  logic lfound;
  logic [CntW-1:0] lsel;
  always_comb begin
    lfound = 1'b0;
    lsel = '0;
    for (int n = Lim - 1; n >= 0; n--) begin
      if (CntW'(n) < rc_r && rp_r[n] == i_r) begin
        lfound = 1'b1;
        lsel = CntW'(n);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_ch.valid && in_ch.data.action == ActCompute) state_nxt = S_COPY;
      S_COPY: state_nxt = S_COPYW;
      S_COPYW: if (k_r + 1'b1 == rc_r) state_nxt = S_SCAN; else state_nxt = S_COPY;
      S_SCAN: if (!probe && i_r + 1'b1 == lc_r && j_r + 1'b1 == rc_r) state_nxt = S_CLR;
      S_CLR: if (k_r >= best_len_r) state_nxt = S_GRD;
      S_GRD: if (j_r == rc_r) state_nxt = S_LEFT;
        else if (rp_r[j_r[AW-1:0]] == None) state_nxt = S_MOD;
      S_MOD: if (col_r < lc_r) state_nxt = S_GRD2;
      S_GRD2: if (gbit || cnt_r + 1'b1 == lc_r) state_nxt = S_GRD;
      S_LEFT: if (i_r == lc_r) state_nxt = S_EMIT;
      S_EMIT: if (out_ch.ready && eside_r == SideLeft && eidx_r + 1'b1 == lc_r)
        state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pairs_r <= '0;
      for (int n = 0; n < Lim; n++) begin
        rp_r[n] <= None;
        lp_r[n] <= None;
      end
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid && in_ch.data.action == ActCompute) begin
            lc_r <= lcc;
            rc_r <= rcc;
            lmask_r <= (lcc >= CntW'(32)) ? '1 : ((RowW'(1) << lcc) - 1'b1);
            for (int n = 0; n < Lim; n++) begin
              work_r[n] <= '0;
              rp_r[n] <= None;
              lp_r[n] <= None;
            end
            k_r <= '0;
            pairs_r <= '0;
            best_len_r <= '0;
            bi_r <= '0;
            bj_r <= '0;
          end
        end
        S_COPY: ;
        S_COPYW: begin
          work_r[k_r[AW-1:0]] <= rd & lmask_r;
          k_r <= k_r + 1'b1;
          if (k_r + 1'b1 == rc_r) begin
            i_r <= '0;
            j_r <= '0;
            len_r <= '0;
          end
        end
        S_SCAN: begin
          if (probe) begin
            len_r <= len_r + 1'b1;
          end else begin
            if (len_r > best_len_r) begin
              best_len_r <= len_r;
              bi_r <= i_r;
              bj_r <= j_r;
            end
            len_r <= '0;
            if (j_r + 1'b1 == rc_r) begin
              j_r <= '0;
              i_r <= i_r + 1'b1;
            end else begin
              j_r <= j_r + 1'b1;
            end
            k_r <= '0;
          end
        end
        S_CLR: begin
          if (k_r < best_len_r) begin
            rp_r[rj[AW-1:0]] <= ci;
            for (int n = 0; n < Lim; n++) begin
              work_r[n] <= (AW'(n) == crow) ? '0 : (work_r[n] & ckeep);
            end
            k_r <= k_r + 1'b1;
          end else begin
            pairs_r <= best_len_r;
            j_r <= '0;
          end
        end
        S_GRD: begin
          if (j_r != rc_r) begin
            if (rp_r[j_r[AW-1:0]] == None) begin
              col_r <= j_r;
              cnt_r <= '0;
            end else begin
              j_r <= j_r + 1'b1;
            end
          end else begin
            i_r <= '0;
          end
        end
        S_MOD: begin
          if (col_r >= lc_r) col_r <= col_r - lc_r;
        end
        S_GRD2: begin
          if (gbit) begin
            rp_r[j_r[AW-1:0]] <= col_r;
            pairs_r <= pairs_r + 1'b1;
            for (int n = 0; n < Lim; n++) begin
              work_r[n] <= (AW'(n) == crow) ? '0 : (work_r[n] & ckeep);
            end
            j_r <= j_r + 1'b1;
          end else begin
            cnt_r <= cnt_r + 1'b1;
            col_r <= (col_r + 1'b1 == lc_r) ? '0 : col_r + 1'b1;
            if (cnt_r + 1'b1 == lc_r) j_r <= j_r + 1'b1;
          end
        end
        S_LEFT: begin
          if (i_r != lc_r) begin
            if (lfound) lp_r[i_r[AW-1:0]] <= lsel;
            i_r <= i_r + 1'b1;
          end else begin
            eside_r <= SideRight;
            eidx_r <= '0;
          end
        end
        S_EMIT: begin
          if (out_ch.ready) begin
            if (eside_r == SideRight && eidx_r + 1'b1 == rc_r) begin
              eside_r <= SideLeft;
              eidx_r <= '0;
            end else begin
              eidx_r <= eidx_r + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  logic [CntW-1:0] psel;
  assign psel = (eside_r == SideRight) ? rp_r[eidx_r[AW-1:0]] : lp_r[eidx_r[AW-1:0]];
  assign out_ch.valid = (state_r == S_EMIT);
  assign out_ch.data.side = eside_r;
  assign out_ch.data.word_index = eidx_r[IdxW-1:0];
  assign out_ch.data.partner_valid = (psel != None);
  assign out_ch.data.partner_index = (psel != None) ? psel[IdxW-1:0] : '0;
  assign out_ch.data.aligned_total = pairs_r;
  assign out_ch.data.last = (eside_r == SideLeft) && (eidx_r + 1'b1 == lc_r);

  `LRWA_ASSERT_IMP(a_busy_not_ready, clk, rst_n, state_r != S_IDLE, !in_ch.ready)
  `LRWA_ASSERT_IMP(a_valid_emit, clk, rst_n, out_ch.valid, state_r == S_EMIT)
  `LRWA_ASSERT_NEXT(a_last_idle, clk, rst_n,
    out_ch.valid && out_ch.ready && out_ch.data.last, state_r == S_IDLE)
endmodule

// ----- dv/longest_run_word_aligner_test.sv -----
// ---------------------------------------------------------------------------
// Longest-run word aligner testbench
// Loads match rows and issues compute transactions with random source gaps
// and sink stalls. A scoreboard predicts each alignment run and checks every
// result transaction in order, field by field.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module longest_run_word_aligner_test;
  import lrwa_pkg::*;

  localparam int WordLimit = 32;
  localparam int NoPartner = 63;
  localparam int StallLimit = 200000;
  localparam int RandomItems = 300;

  logic clk;
  logic rst_n;
  int errors = 0;
  bit calm = 1'b0;
  int quiet_cycles = 0;

  lrwa_in_if in_ch ();
  lrwa_out_if out_ch ();

  longest_run_word_aligner dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  task automatic report(string what, int got, int want);
    $display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  class alignment_scoreboard;
    logic [RowW-1:0] rows[WordLimit];
    int right_link[WordLimit];
    int left_link[WordLimit];
    int pairs;
    out_item_t pending_results[$];

    function int clamp_count(int c);
      if (c == 0) return 1;
      if (c > WordLimit) return WordLimit;
      return c;
    endfunction

    function void align(int lc, int rc);
      logic [RowW-1:0] work[WordLimit];
      logic [RowW-1:0] lmask;
      int best_len, best_i, best_j, len, col;
      best_len = 0;
      best_i = 0;
      best_j = 0;
      lmask = (lc >= 32) ? '1 : ((32'd1 << lc) - 1);
      foreach (work[j]) work[j] = (j < rc) ? (rows[j] & lmask) : '0;
      foreach (right_link[j]) begin
        right_link[j] = NoPartner;
        left_link[j] = NoPartner;
      end
      for (int i = 0; i < lc; i++) begin
        for (int j = 0; j < rc; j++) begin
          len = 0;
          while (i + len < lc && j + len < rc && work[j + len][i + len]) len++;
          if (len > best_len) begin
            best_len = len;
            best_i = i;
            best_j = j;
          end
        end
      end
      for (int k = 0; k < best_len; k++) right_link[best_j + k] = best_i + k;
      pairs = best_len;
      for (int k = 0; k < best_len; k++) begin
        work[best_j + k] = '0;
        for (int r = 0; r < rc; r++) work[r][best_i + k] = 1'b0;
      end
      for (int j = 0; j < rc; j++) begin
        if (right_link[j] != NoPartner) continue;
        col = j % lc;
        for (int n = 0; n < lc; n++) begin
          if (work[j][col]) begin
            work[j] = '0;
            for (int r = 0; r < rc; r++) work[r][col] = 1'b0;
            right_link[j] = col;
            pairs = (pairs + 1) & 63;
            break;
          end
          col = (col + 1) % lc;
        end
      end
      for (int i = 0; i < lc; i++) begin
        for (int j = 0; j < rc; j++) begin
          if (right_link[j] == i) begin
            left_link[i] = j;
            break;
          end
        end
      end
    endfunction

    function void queue_result(logic side, int idx, int partner, bit is_last);
      out_item_t r;
      r.side = side;
      r.word_index = IdxW'(idx);
      r.partner_valid = (partner != NoPartner);
      r.partner_index = (partner != NoPartner) ? IdxW'(partner) : '0;
      r.aligned_total = CntW'(pairs);
      r.last = is_last;
      pending_results = {pending_results, r};
    endfunction

    function void note_input(in_item_t it);
      int lc, rc;
      if (it.action == ActLoad) begin
        rows[it.row_index] = it.row_bits;
        return;
      end
      lc = clamp_count(int'(it.left_count));
      rc = clamp_count(int'(it.right_count));
      align(lc, rc);
      for (int k = 0; k < rc; k++) queue_result(SideRight, k, right_link[k], 1'b0);
      for (int k = 0; k < lc; k++) queue_result(SideLeft, k, left_link[k], k + 1 == lc);
    endfunction

    task check_result(out_item_t got);
      out_item_t want;
      if (pending_results.size() == 0) begin
        report("unexpected result transaction", int'(got.word_index), -1);
        return;
      end
      want = pending_results.pop_front();
      if (got.side !== want.side) report("side", int'(got.side), int'(want.side));
      if (got.word_index !== want.word_index)
        report("word_index", int'(got.word_index), int'(want.word_index));
      if (got.partner_valid !== want.partner_valid)
        report("partner_valid", int'(got.partner_valid), int'(want.partner_valid));
      if (got.partner_index !== want.partner_index)
        report("partner_index", int'(got.partner_index), int'(want.partner_index));
      if (got.aligned_total !== want.aligned_total)
        report("aligned_total", int'(got.aligned_total), int'(want.aligned_total));
      if (got.last !== want.last) report("last", int'(got.last), int'(want.last));
    endtask
  endclass

  alignment_scoreboard scoreboard = new();

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
  end

  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= calm || ($urandom_range(99) >= 23);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) scoreboard.note_input(in_ch.data);
      if (out_ch.valid && out_ch.ready) scoreboard.check_result(out_ch.data);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("watchdog expired at %0t", $realtime);
        $display("** longest_run_word_aligner: FAILED **");
        $finish;
      end
    end
  end

  task automatic send(in_item_t it);
    while (!calm && $urandom_range(99) < 23) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
  endtask

  task automatic load_row(int r, logic [RowW-1:0] bits);
    in_item_t it;
    it.action = ActLoad;
    it.row_index = IdxW'(r);
    it.row_bits = bits;
    it.left_count = CntW'($urandom);
    it.right_count = CntW'($urandom);
    send(it);
  endtask

  task automatic compute(int lc, int rc);
    in_item_t it;
    it.action = ActCompute;
    it.row_index = IdxW'($urandom);
    it.row_bits = $urandom;
    it.left_count = CntW'(lc);
    it.right_count = CntW'(rc);
    send(it);
  endtask

  function automatic logic [RowW-1:0] rotl(logic [RowW-1:0] v, int n);
    return (v << n) | (v >> (RowW - n));
  endfunction

  initial begin
    logic [RowW-1:0] seed;
    int r;
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    @(posedge clk iff rst_n);
    for (int j = 0; j < WordLimit; j++)
      load_row(j, (j == 0) ? '1 : (j == 1) ? '0 : rotl(32'h0000_0F0F, j));
    compute(1, 1);
    compute(0, 0);
    compute(63, 40);
    compute(32, 1);
    compute(1, 32);
    for (int j = 0; j < 4; j++) load_row(j, '0);
    compute(4, 4);
    for (int j = 0; j < 4; j++) load_row(j, 32'd1 << (j + 1));
    compute(5, 4);
    compute(3, 6);

    seed = $urandom;
    for (int n = 0; n < RandomItems; n++) begin
      calm = (n >= 150 && n < 200);
      if ($urandom_range(3) != 0) begin
        r = $urandom_range(31);
        case ($urandom_range(3))
          0: load_row(r, $urandom);
          1: load_row(r, $urandom & $urandom & $urandom);
          2: load_row(r, $urandom_range(1) ? '1 : '0);
          default: load_row(r, rotl(seed, r));
        endcase
        if ($urandom_range(15) == 0) seed = $urandom;
      end else if ($urandom_range(24) == 0) begin
        compute($urandom_range(63), $urandom_range(63));
      end else begin
        compute($urandom_range(1, 8), $urandom_range(1, 8));
      end
    end
    calm = 1'b0;
    in_ch.valid <= 1'b0;
    @(posedge clk);
    wait (scoreboard.pending_results.size() == 0);
    repeat (100) @(posedge clk);
    if (errors == 0) $display("** longest_run_word_aligner: PASSED **");
    else $display("** longest_run_word_aligner: FAILED **");
    $finish;
  end
endmodule
